[rtl/tews_pkg.sv]
// Shared types and constants for the timed event window scan unit.
// Used by tews_ctrl, tews_datapath and timed_event_window_scan_unit.
package tews_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int TIME_BITS   = 32;
  localparam int TAG_BITS    = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Request codes
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_WINDOW = 2'd3
  } tews_req_e;

  // Reply kinds
  typedef enum logic [2:0] {
    KIND_ADD_ACK    = 3'd0,
    KIND_REMOVE_ACK = 3'd1,
    KIND_CLEAR_ACK  = 3'd2,
    KIND_REPORT     = 3'd3,
    KIND_EMPTY      = 3'd4
  } tews_kind_e;

  // Event phases
  typedef enum logic [1:0] {
    PHASE_START  = 2'd0,
    PHASE_END    = 2'd1,
    PHASE_ACTIVE = 2'd2
  } tews_phase_e;

  // Input beat
  typedef struct packed {
    tews_req_e            req_type;
    logic [TIME_BITS-1:0] event_start;
    logic [TIME_BITS-1:0] event_end;
    logic [TAG_BITS-1:0]  event_tag;
    logic [IDX_W-1:0]     entry_index;
    logic [TIME_BITS-1:0] window_from;
    logic [TIME_BITS-1:0] window_to;
  } tews_req_t;

  // Result beat
  typedef struct packed {
    logic [2:0]           reply_kind;
    logic [IDX_W-1:0]     position;
    logic [TAG_BITS-1:0]  report_tag;
    logic [TIME_BITS-1:0] report_time;
    logic [1:0]           event_phase;
    logic [CNT_W-1:0]     entry_count;
    logic                 fault;
    logic                 last;
  } tews_rsp_t;

  // One table entry
  typedef struct packed {
    logic [TIME_BITS-1:0] t_start;
    logic [TIME_BITS-1:0] t_end;
    logic [TAG_BITS-1:0]  tag;
  } tews_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic search_step;
    logic insert;
    logic remove;
    logic clear;
    logic scan_init;
    logic scan_step;
    logic push_first;
    logic push_second;
    logic ack;
    logic ack_fault;
    logic finish;
  } tews_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    tews_req_e req_type;
    logic      full;
    logic      idx_bad;
    logic      search_more;
    logic      win_skip;
    logic      brk;
    logic      hit_first;
    logic      hit_second;
    logic      scan_last;
  } tews_stat_t;

endpackage

[rtl/timed_event_window_scan_unit.sv]
// Top level of the timed event window scan unit.
// Depends on tews_pkg; instantiates tews_ctrl and tews_datapath.
//
// Usage: a request beat is taken on a rising edge where start is high and
// busy is low; busy then stays high until the request's last result is out.
// Results come on rsp_o, each marked by result_valid_o for exactly one cycle;
// the last result of a request has rsp_o.last set. The receiver has no stall.
// Sequence of a request, from the accepting edge to the final result:
//   clear, remove, add to a full table: decode, then the result.
//   add: decode, then the sorted-position search up to p = position taken
//     (0..15), which compares one table entry per cycle through the single
//     table read port, then the result.
//   window: decode, then S_SCAN_A and S_SCAN_B for each entry scanned, one
//     per possible report; the scan can break early from S_SCAN_A on an
//     entry. An equal window or an empty table goes straight to the finish
//     and gives one empty marker.
// A new request may be started in the cycle in which the last result shows.
// Reset clears the occupancy count and the sequencer; table contents are not
// cleared and are only read once written.
module timed_event_window_scan_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tews_pkg::tews_req_t req_i,
  output logic                result_valid_o,
  output tews_pkg::tews_rsp_t rsp_o
);
  import tews_pkg::*;

  tews_cmd_t  cmd;
  tews_stat_t stat;

  tews_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  tews_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

endmodule

[rtl/tews_ctrl.sv]
// Sequencer for the timed event window scan unit.
// Depends on tews_pkg; drives tews_datapath through tews_cmd_t.
module tews_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tews_pkg::tews_stat_t stat_i,
  output tews_pkg::tews_cmd_t  cmd_o
);
  import tews_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SCAN_A = 3'd3;
  localparam logic [2:0] S_SCAN_B = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_q, state_d;

  assign busy = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.req_type)
          REQ_ADD: begin
            if (stat_i.full) begin
              cmd_o.ack       = 1'b1;
              cmd_o.ack_fault = 1'b1;
              state_d         = S_IDLE;
            end else begin
              state_d = S_SEARCH;
            end
          end
          REQ_REMOVE: begin
            cmd_o.ack       = 1'b1;
            cmd_o.ack_fault = stat_i.idx_bad;
            cmd_o.remove    = !stat_i.idx_bad;
            state_d         = S_IDLE;
          end
          REQ_CLEAR: begin
            cmd_o.ack   = 1'b1;
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end
          REQ_WINDOW: begin
            cmd_o.scan_init = 1'b1;
            state_d         = stat_i.win_skip ? S_FINISH : S_SCAN_A;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SEARCH: begin
        // walk past entries that start at or before the new one
        if (stat_i.search_more) begin
          cmd_o.search_step = 1'b1;
        end else begin
          cmd_o.insert = 1'b1;
          cmd_o.ack    = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SCAN_A: begin
        if (stat_i.brk) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.push_first = stat_i.hit_first;
          state_d          = S_SCAN_B;
        end
      end
      S_SCAN_B: begin
        cmd_o.push_second = stat_i.hit_second;
        if (stat_i.scan_last) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d         = S_SCAN_A;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/tews_datapath.sv]
// Event table, scan compare logic and result registers.
// Depends on tews_pkg; commanded by tews_ctrl.
module tews_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tews_pkg::tews_req_t  req_i,
  input  tews_pkg::tews_cmd_t  cmd_i,
  output tews_pkg::tews_stat_t stat_o,
  output logic                 result_valid_o,
  output tews_pkg::tews_rsp_t  rsp_o
);
  import tews_pkg::*;

  tews_req_t            req_q;
  tews_entry_t          ent_q [TABLE_DEPTH];
  tews_entry_t          ent_d [TABLE_DEPTH];
  tews_entry_t          new_ent;
  tews_entry_t          cur;
  logic [CNT_W-1:0]     occ_q, occ_d;
  logic [IDX_W-1:0]     ptr_q, ptr_d;
  logic                 fwd_q, fwd_d;
  tews_rsp_t            pend_q, pend_d;
  logic                 pend_valid_q, pend_valid_d;
  tews_rsp_t            out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic [TIME_BITS-1:0] a_t, b_t, lo_t, hi_t, to_t;
  logic                 a_in, b_in, b_beyond, is_tick;
  tews_rsp_t            rep;

  // Single table read port, shared by search and scan
  assign cur     = ent_q[ptr_q];
  assign new_ent = '{t_start: req_q.event_start, t_end: req_q.event_end, tag: req_q.event_tag};

  // Scan compares: forward looks at start first, backward at end first
  assign to_t     = req_q.window_to;
  assign a_t      = fwd_q ? cur.t_start : cur.t_end;
  assign b_t      = fwd_q ? cur.t_end : cur.t_start;
  assign lo_t     = fwd_q ? req_q.window_from : req_q.window_to;
  assign hi_t     = fwd_q ? req_q.window_to : req_q.window_from;
  assign a_in     = (a_t >= lo_t) && (a_t < hi_t);
  assign b_in     = (b_t >= lo_t) && (b_t < hi_t);
  assign b_beyond = fwd_q ? (b_t > to_t) : (b_t < to_t);
  assign is_tick  = (cur.t_start == cur.t_end);

  // Status back to the sequencer
  always_comb begin
    stat_o.req_type    = req_q.req_type;
    stat_o.full        = (occ_q >= CNT_W'(TABLE_DEPTH));
    stat_o.idx_bad     = ({1'b0, req_q.entry_index} >= occ_q);
    stat_o.search_more = ({1'b0, ptr_q} < occ_q) && !(req_q.event_start < cur.t_start);
    stat_o.win_skip    = (occ_q == '0) || (req_q.window_from == req_q.window_to);
    stat_o.brk         = fwd_q ? (a_t > to_t) : (a_t < to_t);
    stat_o.hit_first   = a_in;
    stat_o.hit_second  = !is_tick && (b_in || b_beyond);
    stat_o.scan_last   = fwd_q ? ({1'b0, ptr_q} == CNT_W'(occ_q - CNT_W'(1))) : (ptr_q == '0);
  end

  // Per-entry shift for insert and remove
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_ent
    localparam int KP = (k == 0) ? 0 : k - 1;
    localparam int KN = (k == TABLE_DEPTH - 1) ? k : k + 1;
    localparam logic [IDX_W-1:0] KI = IDX_W'(k);

    always_comb begin
      ent_d[k] = ent_q[k];
      if (cmd_i.insert) begin
        if (KI == ptr_q) begin
          ent_d[k] = new_ent;
        end else if (KI > ptr_q) begin
          ent_d[k] = ent_q[KP];
        end
      end else if (cmd_i.remove) begin
        if (KI >= req_q.entry_index) begin
          ent_d[k] = ent_q[KN];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      ent_q[k] <= ent_d[k];
    end
  end

  // Report candidate for the current step
  always_comb begin
    rep             = '0;
    rep.reply_kind  = KIND_REPORT;
    rep.position    = ptr_q;
    rep.report_tag  = cur.tag;
    rep.entry_count = occ_q;
    if (cmd_i.push_first) begin
      rep.report_time = a_t;
      rep.event_phase = PHASE_START;
    end else if (b_in) begin
      rep.report_time = b_t;
      rep.event_phase = PHASE_END;
    end else begin
      rep.report_time = to_t;
      rep.event_phase = PHASE_ACTIVE;
    end
  end

  // Occupancy, pointer, direction
  always_comb begin
    occ_d = occ_q;
    ptr_d = ptr_q;
    fwd_d = fwd_q;
    if (cmd_i.insert) begin
      occ_d = occ_q + CNT_W'(1);
    end else if (cmd_i.remove) begin
      occ_d = occ_q - CNT_W'(1);
    end else if (cmd_i.clear) begin
      occ_d = '0;
    end
    if (cmd_i.load) begin
      ptr_d = '0;
    end else if (cmd_i.search_step) begin
      ptr_d = ptr_q + IDX_W'(1);
    end else if (cmd_i.scan_init) begin
      fwd_d = (req_q.window_from < req_q.window_to);
      ptr_d = fwd_d ? '0 : IDX_W'(occ_q - CNT_W'(1));
    end else if (cmd_i.scan_step) begin
      ptr_d = fwd_q ? ptr_q + IDX_W'(1) : ptr_q - IDX_W'(1);
    end
  end

  // Result staging: one report is held back so the final one can carry last
  always_comb begin
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = 1'b0;
    if (cmd_i.ack) begin
      out_d             = '0;
      out_d.reply_kind  = {1'b0, req_q.req_type};
      out_d.entry_count = occ_d;
      out_d.fault       = cmd_i.ack_fault;
      out_d.last        = 1'b1;
      if (req_q.req_type == REQ_ADD) begin
        out_d.position = ptr_q;
      end else if (req_q.req_type == REQ_REMOVE) begin
        out_d.position = req_q.entry_index;
      end
      out_valid_d = 1'b1;
    end else if (cmd_i.scan_init) begin
      pend_valid_d = 1'b0;
    end else if (cmd_i.push_first || cmd_i.push_second) begin
      if (pend_valid_q) begin
        out_d       = pend_q;
        out_valid_d = 1'b1;
      end
      pend_d       = rep;
      pend_valid_d = 1'b1;
    end else if (cmd_i.finish) begin
      if (pend_valid_q) begin
        out_d      = pend_q;
        out_d.last = 1'b1;
      end else begin
        out_d             = '0;
        out_d.reply_kind  = KIND_EMPTY;
        out_d.entry_count = occ_q;
        out_d.last        = 1'b1;
      end
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q        <= '0;
      ptr_q        <= '0;
      fwd_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      occ_q        <= occ_d;
      ptr_q        <= ptr_d;
      fwd_q        <= fwd_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign result_valid_o = out_valid_q;
  assign rsp_o          = out_q;

endmodule
